### sv/tccw_pkg.sv
// Package with shared types and constants for the text console character writer.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row_now;
    logic [6:0]  cursor_col_now;
    logic        scrolled;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_SC_COPY,
    ST_SC_DRAIN,
    ST_SC_FILL
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

### sv/tccw_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tccw_addr_unit.sv
// Shared address adder/subtractor for cursor, read and scroll addressing.
`timescale 1ns / 1ps

module tccw_addr_unit #(
  parameter int AW = 11
) (
  input  tccw_pkg::alu_op_t op,
  input  logic [AW-1:0]     a,
  input  logic [AW-1:0]     b,
  output logic [AW-1:0]     sum
);

  always_comb begin
    case (op)
      tccw_pkg::ALU_ADD: sum = a + b;
      tccw_pkg::ALU_SUB: sum = a - b;
      default:           sum = a;
    endcase
  end

endmodule

### sv/text_console_char_writer_unit.sv
// Top level of the text console character writer: sequencer, cursor and screen buffer.
//
//   channel | ports                      | handshake
//   --------+----------------------------+-------------------------------------
//   input   | start, busy, in_item       | transfer when start && !busy
//   result  | out_valid, out_item        | one-cycle strobe, no back-pressure
//
// After reset a clearing pass writes ROWS*COLUMNS cells, one per cycle, with busy high.
// A put runs ST_PUT, a read ST_RD_ISSUE then ST_RD_DATA, and an out-of-range read is answered from idle;
// the result is registered from the last state. A scroll then copies through the single RAM port pair,
// drains and fills the last row; the shared address adder and the one RAM write port set this order.
// Results cannot be stalled; busy holds off new items while the sequencer runs.
`timescale 1ns / 1ps

module text_console_char_writer_unit #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tccw_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tccw_pkg::out_item_t out_item
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);

  tccw_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  tccw_pkg::in_item_t  item_r, item_nxt;
  logic [AW-1:0]       mul_r, mul_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  tccw_pkg::out_item_t out_r, out_nxt;

  tccw_pkg::alu_op_t   alu_op;
  logic [AW-1:0]       alu_a, alu_b, alu_sum;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;

  logic [RW:0]         row_p1, row_n;
  logic [CW:0]         col_p1, col_n;
  logic                put_write, do_scroll, read_ok;
  logic [31:0]         row_w, col_w;

  tccw_addr_unit #(.AW(AW)) u_addr (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  tccw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccw_pkg::ST_CLEAR;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    mul_r     <= mul_nxt;
    wr_addr_r <= wr_addr_nxt;
    out_r     <= out_nxt;
  end

  // Cursor step for the latched character
  always_comb begin
    row_p1    = {1'b0, row_r} + 1'b1;
    col_p1    = {1'b0, col_r} + 1'b1;
    put_write = 1'b0;
    row_n     = {1'b0, row_r};
    col_n     = {1'b0, col_r};
    if (item_r.char_code == tccw_pkg::CH_NEWLINE) begin
      row_n = row_p1;
    end else if (item_r.char_code == tccw_pkg::CH_RETURN) begin
      col_n = '0;
    end else begin
      put_write = 1'b1;
      if (col_p1 == (CW+1)'(COLUMNS)) begin
        col_n = '0;
        row_n = row_p1;
      end else begin
        col_n = col_p1;
      end
    end
    do_scroll = (row_n == (RW+1)'(ROWS));
    read_ok   = (32'(in_item.read_row) < 32'(ROWS)) && (32'(in_item.read_col) < 32'(COLUMNS));
  end

  // Address unit operand select
  always_comb begin
    alu_op = tccw_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state_r)
      tccw_pkg::ST_PUT: begin
        alu_a = pos_r;
        if (item_r.char_code == tccw_pkg::CH_NEWLINE) begin
          alu_b = AW'(COLUMNS);
        end else if (item_r.char_code == tccw_pkg::CH_RETURN) begin
          alu_op = tccw_pkg::ALU_SUB;
          alu_b  = AW'(col_r);
        end else begin
          alu_b = AW'(1);
        end
      end
      tccw_pkg::ST_RD_ISSUE: begin
        alu_a = mul_r;
        alu_b = AW'(item_r.read_col);
      end
      tccw_pkg::ST_SC_COPY: begin
        alu_a = cnt_r;
        alu_b = AW'(COLUMNS);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // RAM port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_r)
      tccw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      tccw_pkg::ST_PUT: begin
        ram_we    = put_write;
        ram_waddr = pos_r;
        ram_wdata = {item_r.attribute, item_r.char_code};
      end
      tccw_pkg::ST_RD_ISSUE: begin
        ram_raddr = alu_sum;
      end
      tccw_pkg::ST_SC_COPY: begin
        ram_we    = wr_pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
        ram_raddr = alu_sum;
      end
      tccw_pkg::ST_SC_DRAIN: begin
        ram_we    = wr_pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
      end
      tccw_pkg::ST_SC_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {item_r.attribute, tccw_pkg::CH_SPACE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    mul_nxt       = mul_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    pos_nxt       = pos_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    row_w         = 32'(row_r);
    col_w         = 32'(col_r);
    case (state_r)
      tccw_pkg::ST_CLEAR: begin
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tccw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          mul_nxt  = AW'(32'(in_item.read_row) * 32'(COLUMNS));
          if (in_item.command == tccw_pkg::CMD_PUT) begin
            state_nxt = tccw_pkg::ST_PUT;
          end else if (read_ok) begin
            state_nxt = tccw_pkg::ST_RD_ISSUE;
          end else begin
            out_valid_nxt          = 1'b1;
            out_nxt.cell_value     = '0;
            out_nxt.cursor_row_now = row_w[4:0];
            out_nxt.cursor_col_now = col_w[6:0];
            out_nxt.scrolled       = 1'b0;
          end
        end
      end
      tccw_pkg::ST_PUT: begin
        if (do_scroll) begin
          row_nxt   = RW'(ROWS - 1);
          col_nxt   = '0;
          pos_nxt   = AW'(COPY_N);
          cnt_nxt   = '0;
          state_nxt = tccw_pkg::ST_SC_COPY;
        end else begin
          row_nxt                = row_n[RW-1:0];
          col_nxt                = col_n[CW-1:0];
          pos_nxt                = alu_sum;
          row_w                  = 32'(row_n);
          col_w                  = 32'(col_n);
          out_valid_nxt          = 1'b1;
          out_nxt.cell_value     = '0;
          out_nxt.cursor_row_now = row_w[4:0];
          out_nxt.cursor_col_now = col_w[6:0];
          out_nxt.scrolled       = 1'b0;
          state_nxt              = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_RD_ISSUE: begin
        state_nxt = tccw_pkg::ST_RD_DATA;
      end
      tccw_pkg::ST_RD_DATA: begin
        out_valid_nxt          = 1'b1;
        out_nxt.cell_value     = ram_rdata;
        out_nxt.cursor_row_now = row_w[4:0];
        out_nxt.cursor_col_now = col_w[6:0];
        out_nxt.scrolled       = 1'b0;
        state_nxt              = tccw_pkg::ST_IDLE;
      end
      tccw_pkg::ST_SC_COPY: begin
        wr_pend_nxt = 1'b1;
        if (cnt_r == AW'(COPY_N - 1)) begin
          state_nxt = tccw_pkg::ST_SC_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tccw_pkg::ST_SC_DRAIN: begin
        cnt_nxt   = AW'(COPY_N);
        state_nxt = tccw_pkg::ST_SC_FILL;
      end
      tccw_pkg::ST_SC_FILL: begin
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt                = '0;
          out_valid_nxt          = 1'b1;
          out_nxt.cell_value     = '0;
          out_nxt.cursor_row_now = row_w[4:0];
          out_nxt.cursor_col_now = col_w[6:0];
          out_nxt.scrolled       = 1'b1;
          state_nxt              = tccw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != tccw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
